### src/bfd_pkg.sv
// Shared constants and types for the 2x2 box-filter downsampler.
package bfd_pkg;

  localparam int MAX_OUT_WIDTH  = 1024;
  localparam int MAX_OUT_HEIGHT = 1024;

  localparam int DIM_W  = 11;
  localparam int ADDR_W = $clog2(MAX_OUT_WIDTH);
  localparam int CH_W   = 8;
  localparam int PAIR_W = CH_W + 1;
  localparam int QUAD_W = CH_W + 2;
  localparam int LINE_W = 3 * PAIR_W;
  localparam int PADDR_W = 3;

  localparam logic [DIM_W-1:0] MAX_W_DIM   = DIM_W'(MAX_OUT_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM   = DIM_W'(MAX_OUT_HEIGHT);
  localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [QUAD_W-1:0] ROUND_BIAS = QUAD_W'(2);

  // Register indexes on the configuration port.
  localparam logic REG_OUT_WIDTH  = 1'b0;
  localparam logic REG_OUT_HEIGHT = 1'b1;

  typedef logic [PAIR_W-1:0] pair_sum_t;

  // Clamp a programmed size: zero acts as one, oversize acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### src/box_filter_downsample_2x2_top.sv
// Top level of the 2x2 box-filter downsampler with its line buffer.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   in_red, in_green, in_blue
//   out_      output     out_valid/out_stall out_red/green/blue/alpha, out_frame_last
//   config    APB        psel/penable/pready out_width (0x0), out_height (0x4)
//
// One input pixel is taken per clock unless in_stall is high; the single-port
// line buffer is written or read once per right-hand pixel.
// A completed block is registered in the result stage, then in the output registers.
// rst_n is synchronous; the line buffer is not cleared and is always written
// on an even row before the odd row below reads it.
// A stalled output holds the result stage, which stalls the input only when full.
module box_filter_downsample_2x2_top
  import bfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CH_W-1:0]    in_red,
  input  logic [CH_W-1:0]    in_green,
  input  logic [CH_W-1:0]    in_blue,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [CH_W-1:0]    out_red,
  output logic [CH_W-1:0]    out_green,
  output logic [CH_W-1:0]    out_blue,
  output logic [CH_W-1:0]    out_alpha,
  output logic               out_frame_last,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers.
  logic [DIM_W-1:0] out_width_r;
  logic [DIM_W-1:0] out_height_r;
  logic             cfg_wr;
  logic             cfg_sel;

  // Frame position.
  logic             col_phase_r;
  logic             row_phase_r;
  logic [DIM_W-1:0] col_count_r;
  logic [DIM_W-1:0] row_count_r;
  logic [CH_W-1:0]  held_red_r;
  logic [CH_W-1:0]  held_green_r;
  logic [CH_W-1:0]  held_blue_r;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic             last_col;
  logic             last_row;
  logic [ADDR_W-1:0] line_idx;

  logic             acc;
  logic             s1_move;
  logic             produce;

  pair_sum_t        pair_red;
  pair_sum_t        pair_green;
  pair_sum_t        pair_blue;

  // Line buffer.
  logic [LINE_W-1:0] line_mem [MAX_OUT_WIDTH];
  logic [LINE_W-1:0] above_r;

  // Result stage: pair sums of the lower row wait for the line buffer read.
  logic             s1_valid_r;
  pair_sum_t        s1_red_r;
  pair_sum_t        s1_green_r;
  pair_sum_t        s1_blue_r;
  logic             s1_last_r;

  logic [QUAD_W-1:0] quad_red;
  logic [QUAD_W-1:0] quad_green;
  logic [QUAD_W-1:0] quad_blue;

  logic             out_valid_r;
  logic [CH_W-1:0]  out_red_r;
  logic [CH_W-1:0]  out_green_r;
  logic [CH_W-1:0]  out_blue_r;
  logic             out_last_r;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_sel)
      REG_OUT_WIDTH:  prdata = 32'(out_width_r);
      REG_OUT_HEIGHT: prdata = 32'(out_height_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= DIM_W'(710);
      out_height_r <= DIM_W'(180);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_OUT_WIDTH:  out_width_r  <= pwdata[DIM_W-1:0];
        REG_OUT_HEIGHT: out_height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff    = clamp_dim(out_width_r, MAX_W_DIM);
  assign h_eff    = clamp_dim(out_height_r, MAX_H_DIM);
  assign last_col = col_count_r >= (w_eff - DIM_W'(1));
  assign last_row = row_count_r >= (h_eff - DIM_W'(1));
  assign line_idx = (col_count_r >= MAX_W_DIM) ? ADDR_W'(MAX_OUT_WIDTH - 1)
                                               : col_count_r[ADDR_W-1:0];

  assign s1_move  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_move;
  assign acc      = in_valid && !in_stall;
  assign produce  = col_phase_r && row_phase_r;

  assign pair_red   = PAIR_W'(held_red_r)   + PAIR_W'(in_red);
  assign pair_green = PAIR_W'(held_green_r) + PAIR_W'(in_green);
  assign pair_blue  = PAIR_W'(held_blue_r)  + PAIR_W'(in_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_phase_r  <= 1'b0;
      row_phase_r  <= 1'b0;
      col_count_r  <= '0;
      row_count_r  <= '0;
      held_red_r   <= '0;
      held_green_r <= '0;
      held_blue_r  <= '0;
    end else if (cfg_wr) begin
      // Any register write restarts the frame.
      col_phase_r  <= 1'b0;
      row_phase_r  <= 1'b0;
      col_count_r  <= '0;
      row_count_r  <= '0;
      held_red_r   <= '0;
      held_green_r <= '0;
      held_blue_r  <= '0;
    end else if (acc) begin
      if (!col_phase_r) begin
        held_red_r   <= in_red;
        held_green_r <= in_green;
        held_blue_r  <= in_blue;
        col_phase_r  <= 1'b1;
      end else begin
        col_phase_r <= 1'b0;
        if (last_col) begin
          col_count_r <= '0;
          if (!row_phase_r) begin
            row_phase_r <= 1'b1;
          end else begin
            row_phase_r <= 1'b0;
            row_count_r <= last_row ? '0 : row_count_r + DIM_W'(1);
          end
        end else begin
          col_count_r <= col_count_r + DIM_W'(1);
        end
      end
    end
  end

  // Even rows write pair sums; odd rows read the entry the row above left.
  // The write lands at the transfer edge, long before the row below reads it.
  always_ff @(posedge clk) begin
    if (acc && col_phase_r) begin
      if (!row_phase_r) begin
        line_mem[line_idx] <= {pair_red, pair_green, pair_blue};
      end else begin
        above_r <= line_mem[line_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= produce;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && produce) begin
      s1_red_r   <= pair_red;
      s1_green_r <= pair_green;
      s1_blue_r  <= pair_blue;
      s1_last_r  <= last_col && last_row;
    end
  end

  assign quad_red   = QUAD_W'(s1_red_r) + QUAD_W'(above_r[3*PAIR_W-1:2*PAIR_W]) + ROUND_BIAS;
  assign quad_green = QUAD_W'(s1_green_r) + QUAD_W'(above_r[2*PAIR_W-1:PAIR_W]) + ROUND_BIAS;
  assign quad_blue  = QUAD_W'(s1_blue_r) + QUAD_W'(above_r[PAIR_W-1:0]) + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid_r) begin
      out_red_r   <= quad_red[QUAD_W-1:2];
      out_green_r <= quad_green[QUAD_W-1:2];
      out_blue_r  <= quad_blue[QUAD_W-1:2];
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_alpha      = ALPHA_OPAQUE;
  assign out_frame_last = out_last_r;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_count_r < w_eff)
    else $error("column counter beyond the output width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r < h_eff)
    else $error("row counter beyond the output height");

  a_result_on_odd_right: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !cfg_wr && col_phase_r && row_phase_r |=> s1_valid_r)
    else $error("completed block did not enter the result stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_red_r) && $stable(above_r))
    else $error("result stage lost its contents under stall");

endmodule
